[src/mbsa_pkg.sv]
`timescale 1ns / 1ps
// shared types, codes and constants of the midi byte stream assembler
package mbsa_pkg;

    localparam int BUFFER_BYTES_DEF = 1024;
    localparam int DONE_W = 11;
    localparam int LEN_W = 5;
    localparam int CHUNK_BYTES = 16;

    typedef struct packed {
        logic       mode;
        logic [7:0] in_byte;
    } item_t;

    typedef struct packed {
        logic [DONE_W-1:0] done_count;
        logic [1:0]        send_kind;
        logic [63:0]       chunk_low;
        logic [63:0]       chunk_high;
        logic [LEN_W-1:0]  chunk_len;
        logic              last;
    } result_t;

    // send kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_CHUNK = 2'd2;

    // result select codes
    localparam logic [2:0] OSEL_SINGLE = 3'd0;
    localparam logic [2:0] OSEL_SYS    = 3'd1;
    localparam logic [2:0] OSEL_SHORT2 = 3'd2;
    localparam logic [2:0] OSEL_SHORT3 = 3'd3;
    localparam logic [2:0] OSEL_CHUNK  = 3'd4;
    localparam logic [2:0] OSEL_RESET  = 3'd5;

    // fill position operations
    localparam logic [1:0] FILL_HOLD  = 2'd0;
    localparam logic [1:0] FILL_FIRST = 2'd1;
    localparam logic [1:0] FILL_RUN   = 2'd2;
    localparam logic [1:0] FILL_STEP  = 2'd3;

    // midi byte values
    localparam logic [7:0] BYTE_SOX       = 8'hf0;
    localparam logic [7:0] BYTE_TIMECODE  = 8'hf1;
    localparam logic [7:0] BYTE_SONG_POS  = 8'hf2;
    localparam logic [7:0] BYTE_SONG_SEL  = 8'hf3;
    localparam logic [7:0] BYTE_TUNE_REQ  = 8'hf6;
    localparam logic [7:0] BYTE_EOX       = 8'hf7;
    localparam logic [7:0] BYTE_CLOCK     = 8'hf8;
    localparam logic [7:0] BYTE_START     = 8'hfa;
    localparam logic [7:0] BYTE_CONTINUE  = 8'hfb;
    localparam logic [7:0] BYTE_STOP      = 8'hfc;
    localparam logic [7:0] BYTE_SENSING   = 8'hfe;
    localparam logic [7:0] BYTE_SYS_RESET = 8'hff;
    localparam logic [7:0] BYTE_NON_RT    = 8'h7e;
    localparam logic [7:0] BYTE_RT        = 8'h7f;
    localparam logic [7:0] DATA_MASK      = 8'h7f;
    localparam logic [7:0] LAST_STATUS_RST = 8'h80;
    localparam logic [3:0] NIBBLE_CC      = 4'hb;
    localparam logic [7:0] CC_NOTES_OFF   = 8'h7b;

    // gm system reset exclusive, byte 0 in bits 7:0
    localparam logic [63:0]      GM_RESET_LOW = 64'h0000_f701_097f_7ef0;
    localparam logic [LEN_W-1:0] GM_RESET_LEN = 5'd6;
    localparam logic [4:0]       RESET_LAST_IDX = 5'd16;

    typedef struct packed {
        logic [1:0] fill_op;
        logic       mem_we;
        logic       set_last;
        logic       sys_load;
        logic [1:0] sys_val;
        logic       out_load;
        logic [2:0] out_sel;
        logic [1:0] done_val;
        logic       chunk_clr;
        logic       chunk_rd;
        logic       chunk_next;
        logic       rst_clr;
        logic       rst_next;
    } mbsa_cmd_t;

    typedef struct packed {
        logic out_free;
        logic fill_ge2;
        logic sys_done;
        logic excl_full;
        logic last_chunk;
        logic rst_last;
    } mbsa_stat_t;

endpackage

[src/mbsa_ctrl.sv]
`timescale 1ns / 1ps
// parser and output sequencer state machines of the midi byte stream assembler
module mbsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  mbsa_pkg::item_t    item,
    input  mbsa_pkg::mbsa_stat_t stat,
    output mbsa_pkg::mbsa_cmd_t  cmd
);
    import mbsa_pkg::*;

    localparam logic [2:0] PS_READY    = 3'd0;
    localparam logic [2:0] PS_TWO      = 3'd1;
    localparam logic [2:0] PS_THREE    = 3'd2;
    localparam logic [2:0] PS_EXCL     = 3'd3;
    localparam logic [2:0] PS_TIMECODE = 3'd4;
    localparam logic [2:0] PS_SYSTEM   = 3'd5;

    localparam logic [1:0] SEQ_IDLE = 2'd0;
    localparam logic [1:0] SEQ_RD   = 2'd1;
    localparam logic [1:0] SEQ_EMIT = 2'd2;
    localparam logic [1:0] SEQ_RST  = 2'd3;

    logic [2:0] parse_reg;
    logic [2:0] parse_next;
    logic [1:0] seq_reg;
    logic [1:0] seq_next;
    logic       accept;
    logic       is_rt;
    logic [7:0] b;

    assign b = item.in_byte;
    assign is_rt = (b == BYTE_CLOCK) || (b == BYTE_START) || (b == BYTE_CONTINUE) ||
                   (b == BYTE_STOP) || (b == BYTE_SENSING) || (b == BYTE_SYS_RESET);
    assign item_ready = (seq_reg == SEQ_IDLE) && stat.out_free;
    assign accept = item_valid && item_ready;

    always_comb
    begin
        cmd = '0;
        parse_next = parse_reg;
        seq_next = seq_reg;
        case (seq_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    if (item.mode)
                    begin
                        cmd.rst_clr = 1'b1;
                        seq_next = SEQ_RST;
                    end
                    else if (is_rt)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel = OSEL_SINGLE;
                        cmd.done_val = 2'd1;
                    end
                    else
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel = OSEL_SINGLE;
                        cmd.done_val = 2'd0;
                        case (parse_reg)
                            PS_READY:
                            begin
                                if (b[7])
                                begin
                                    cmd.fill_op = FILL_FIRST;
                                    case (b[7:4])
                                        4'hc, 4'hd:
                                        begin
                                            parse_next = PS_TWO;
                                        end
                                        4'h8, 4'h9, 4'ha, 4'hb, 4'he:
                                        begin
                                            parse_next = PS_THREE;
                                            cmd.set_last = 1'b1;
                                        end
                                        default:
                                        begin
                                            if (b == BYTE_SOX)
                                            begin
                                                parse_next = PS_EXCL;
                                                cmd.mem_we = 1'b1;
                                            end
                                            else if (b == BYTE_TIMECODE)
                                            begin
                                                parse_next = PS_TIMECODE;
                                                cmd.mem_we = 1'b1;
                                            end
                                            else if (b == BYTE_SONG_POS)
                                            begin
                                                parse_next = PS_SYSTEM;
                                                cmd.sys_load = 1'b1;
                                                cmd.sys_val = 2'd3;
                                            end
                                            else if (b == BYTE_SONG_SEL)
                                            begin
                                                parse_next = PS_SYSTEM;
                                                cmd.sys_load = 1'b1;
                                                cmd.sys_val = 2'd2;
                                            end
                                            else
                                            begin
                                                // tune request completes at once, stray
                                                // status is just acknowledged
                                                cmd.done_val = 2'd1;
                                                if (b == BYTE_TUNE_REQ)
                                                begin
                                                    cmd.sys_load = 1'b1;
                                                    cmd.sys_val = 2'd1;
                                                end
                                            end
                                        end
                                    endcase
                                end
                                else
                                begin
                                    // running status
                                    cmd.fill_op = FILL_RUN;
                                    parse_next = PS_THREE;
                                end
                            end
                            PS_TWO:
                            begin
                                cmd.fill_op = FILL_STEP;
                                cmd.out_sel = OSEL_SHORT2;
                                parse_next = PS_READY;
                            end
                            PS_THREE:
                            begin
                                cmd.fill_op = FILL_STEP;
                                if (stat.fill_ge2)
                                begin
                                    cmd.out_sel = OSEL_SHORT3;
                                    parse_next = PS_READY;
                                end
                            end
                            PS_EXCL:
                            begin
                                cmd.fill_op = FILL_STEP;
                                cmd.mem_we = 1'b1;
                                if (b == BYTE_EOX)
                                begin
                                    cmd.out_load = 1'b0;
                                    cmd.chunk_clr = 1'b1;
                                    parse_next = PS_READY;
                                    seq_next = SEQ_RD;
                                end
                                else if (stat.excl_full)
                                begin
                                    parse_next = PS_READY;
                                end
                            end
                            PS_TIMECODE:
                            begin
                                cmd.fill_op = FILL_STEP;
                                cmd.mem_we = 1'b1;
                                if ((b == BYTE_NON_RT) || (b == BYTE_RT))
                                begin
                                    parse_next = PS_EXCL;
                                end
                                else
                                begin
                                    cmd.done_val = 2'd2;
                                    parse_next = PS_READY;
                                end
                            end
                            PS_SYSTEM:
                            begin
                                cmd.fill_op = FILL_STEP;
                                if (stat.sys_done)
                                begin
                                    cmd.out_sel = OSEL_SYS;
                                    parse_next = PS_READY;
                                end
                            end
                            default:
                            begin
                                parse_next = PS_READY;
                            end
                        endcase
                    end
                end
            end
            SEQ_RD:
            begin
                cmd.chunk_rd = 1'b1;
                seq_next = SEQ_EMIT;
            end
            SEQ_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel = OSEL_CHUNK;
                    if (stat.last_chunk)
                    begin
                        seq_next = SEQ_IDLE;
                    end
                    else
                    begin
                        cmd.chunk_next = 1'b1;
                        seq_next = SEQ_RD;
                    end
                end
            end
            SEQ_RST:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel = OSEL_RESET;
                    if (stat.rst_last)
                    begin
                        seq_next = SEQ_IDLE;
                    end
                    else
                    begin
                        cmd.rst_next = 1'b1;
                    end
                end
            end
            default:
            begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg <= PS_READY;
            seq_reg <= SEQ_IDLE;
        end
        else
        begin
            parse_reg <= parse_next;
            seq_reg <= seq_next;
        end
    end

endmodule

[src/mbsa_datapath.sv]
`timescale 1ns / 1ps
// message store, fill counters and result register of the midi byte stream assembler
module mbsa_datapath #(
    parameter int BUFFER_BYTES = mbsa_pkg::BUFFER_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mbsa_pkg::item_t      item,
    input  mbsa_pkg::mbsa_cmd_t  cmd,
    output mbsa_pkg::mbsa_stat_t stat,
    output logic                 result_valid,
    input  logic                 result_ready,
    output mbsa_pkg::result_t    result
);
    import mbsa_pkg::*;

    localparam int FILL_W = $clog2(BUFFER_BYTES + 1);
    localparam int ROWS = (BUFFER_BYTES + CHUNK_BYTES - 1) / CHUNK_BYTES;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [1:0]        sys_count_reg;
    logic [1:0]        sys_count_next;
    logic [7:0]        last_status_reg;
    logic [7:0]        last_status_next;
    logic [7:0]        byte0_reg;
    logic [7:0]        byte0_next;
    logic [7:0]        byte1_reg;
    logic [7:0]        byte1_next;
    logic [ROW_AW-1:0] chunk_idx_reg;
    logic [ROW_AW-1:0] chunk_idx_next;
    logic [4:0]        rst_idx_reg;
    logic [4:0]        rst_idx_next;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           out_d;

    logic [127:0]      mem [ROWS];
    logic [127:0]      rdata_reg;
    logic [FILL_W-1:0] wr_pos;
    logic [ROW_AW-1:0] wr_row;
    logic [3:0]        wr_lane;

    logic [FILL_W-1:0] chunk_start;
    logic [FILL_W-1:0] chunk_rem;
    logic              last_chunk;
    logic [LEN_W-1:0]  chunk_len;
    logic [127:0]      chunk_bytes;
    logic [4:0]        ch_w;
    logic [7:0]        b;

    assign b = item.in_byte;

    // bytes of the message under assembly
    always_comb
    begin
        fill_next = fill_reg;
        byte0_next = byte0_reg;
        byte1_next = byte1_reg;
        case (cmd.fill_op)
            FILL_FIRST:
            begin
                byte0_next = b;
                fill_next = FILL_W'(1);
            end
            FILL_RUN:
            begin
                byte0_next = last_status_reg;
                byte1_next = b;
                fill_next = FILL_W'(2);
            end
            FILL_STEP:
            begin
                if (fill_reg == FILL_W'(1))
                begin
                    byte1_next = b;
                end
                fill_next = fill_reg + FILL_W'(1);
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    assign last_status_next = cmd.set_last ? b : last_status_reg;
    assign sys_count_next = cmd.sys_load ? cmd.sys_val : sys_count_reg;
    assign chunk_idx_next = cmd.chunk_clr ? '0 :
                            (cmd.chunk_next ? chunk_idx_reg + ROW_AW'(1) : chunk_idx_reg);
    assign rst_idx_next = cmd.rst_clr ? 5'd0 :
                          (cmd.rst_next ? rst_idx_reg + 5'd1 : rst_idx_reg);

    assign wr_pos = (cmd.fill_op == FILL_FIRST) ? '0 : fill_reg;
    assign wr_row = wr_pos[ROW_AW+3:4];
    assign wr_lane = wr_pos[3:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[wr_row][{wr_lane, 3'b000} +: 8] <= b;
        end
        if (cmd.chunk_rd)
        begin
            rdata_reg <= mem[chunk_idx_reg];
        end
    end

    // chunk geometry, fill_reg holds the exclusive length including eox
    assign chunk_start = FILL_W'({chunk_idx_reg, 4'b0000});
    assign chunk_rem = fill_reg - chunk_start;
    assign last_chunk = chunk_rem <= FILL_W'(CHUNK_BYTES);
    assign chunk_len = last_chunk ? chunk_rem[LEN_W-1:0] : LEN_W'(CHUNK_BYTES);

    always_comb
    begin
        for (int i = 0; i < CHUNK_BYTES; i++)
        begin
            chunk_bytes[i*8 +: 8] = (LEN_W'(i) < chunk_len) ? rdata_reg[i*8 +: 8] : 8'h00;
        end
    end

    assign ch_w = rst_idx_reg - 5'd1;

    always_comb
    begin
        out_d = '0;
        out_d.last = 1'b1;
        case (cmd.out_sel)
            OSEL_SINGLE:
            begin
                out_d.done_count = DONE_W'(cmd.done_val);
            end
            OSEL_SYS:
            begin
                out_d.done_count = DONE_W'(sys_count_reg);
            end
            OSEL_SHORT2:
            begin
                out_d.done_count = DONE_W'(2);
                out_d.send_kind = KIND_SHORT;
                out_d.chunk_low = {48'd0, b & DATA_MASK, byte0_reg};
                out_d.chunk_len = LEN_W'(2);
            end
            OSEL_SHORT3:
            begin
                out_d.done_count = DONE_W'(3);
                out_d.send_kind = KIND_SHORT;
                out_d.chunk_low = {40'd0, b & DATA_MASK, byte1_reg & DATA_MASK, byte0_reg};
                out_d.chunk_len = LEN_W'(3);
            end
            OSEL_CHUNK:
            begin
                out_d.done_count = DONE_W'(fill_reg);
                out_d.send_kind = KIND_CHUNK;
                out_d.chunk_low = chunk_bytes[63:0];
                out_d.chunk_high = chunk_bytes[127:64];
                out_d.chunk_len = chunk_len;
                out_d.last = last_chunk;
            end
            OSEL_RESET:
            begin
                out_d.done_count = DONE_W'(1);
                if (rst_idx_reg == 5'd0)
                begin
                    out_d.send_kind = KIND_CHUNK;
                    out_d.chunk_low = GM_RESET_LOW;
                    out_d.chunk_len = GM_RESET_LEN;
                    out_d.last = 1'b0;
                end
                else
                begin
                    // all notes off on channel idx-1
                    out_d.send_kind = KIND_SHORT;
                    out_d.chunk_low = {40'd0, 8'h00, CC_NOTES_OFF, NIBBLE_CC, ch_w[3:0]};
                    out_d.chunk_len = LEN_W'(3);
                    out_d.last = (rst_idx_reg == RESET_LAST_IDX);
                end
            end
            default:
            begin
                out_d.done_count = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            sys_count_reg <= 2'd0;
            last_status_reg <= LAST_STATUS_RST;
            chunk_idx_reg <= '0;
            rst_idx_reg <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            sys_count_reg <= sys_count_next;
            last_status_reg <= last_status_next;
            chunk_idx_reg <= chunk_idx_next;
            rst_idx_reg <= rst_idx_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte0_reg <= byte0_next;
        byte1_reg <= byte1_next;
        if (cmd.out_load)
        begin
            out_reg <= out_d;
        end
    end

    assign result_valid = out_valid_reg;
    assign result = out_reg;

    assign stat.out_free = !out_valid_reg || result_ready;
    assign stat.fill_ge2 = fill_reg >= FILL_W'(2);
    assign stat.sys_done = ({1'b0, fill_reg} + (FILL_W+1)'(1)) >= (FILL_W+1)'(sys_count_reg);
    assign stat.excl_full = ({1'b0, fill_reg} + (FILL_W+1)'(1)) >= (FILL_W+1)'(BUFFER_BYTES);
    assign stat.last_chunk = last_chunk;
    assign stat.rst_last = (rst_idx_reg == RESET_LAST_IDX);

endmodule

[src/midi_byte_stream_assembler_top.sv]
`timescale 1ns / 1ps
// Top level of the midi byte stream assembler. One byte is taken per cycle while the
// result register is free; every byte loads one result into the result register as it
// is accepted, except EOX closing an exclusive message, which gives ceil(n/16) chunks,
// each a read of a 16-byte row of the message store, then the load of the result
// register once it is free, and a reset command, which gives 17 results. During those
// sequences no byte is accepted. The store is BUFFER_BYTES bytes organized as 16-byte
// rows with one byte write port and one row read port; it needs no clearing after reset.
module midi_byte_stream_assembler_top #(
    parameter int BUFFER_BYTES = mbsa_pkg::BUFFER_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  mbsa_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output mbsa_pkg::result_t result
);
    import mbsa_pkg::*;

    mbsa_cmd_t  cmd;
    mbsa_stat_t stat;

    mbsa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .stat       (stat),
        .cmd        (cmd)
    );

    mbsa_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // a new byte is only taken when the result register can accept its result
    assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> (!result_valid || result_ready))
        else $error("item ready while result register is blocked");

    // results of one transaction are never interleaved with a new input
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> !item_ready)
        else $error("input accepted before the final result");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.chunk_len <= 5'd16) && (result.send_kind != 2'd3)))
        else $error("malformed result");

    // nothing forwarded means empty lanes
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.send_kind == KIND_NONE)) |->
            ((result.chunk_len == 5'd0) && (result.chunk_low == 64'd0) &&
             (result.chunk_high == 64'd0)))
        else $error("payload present on empty result");

endmodule

[tb/tb_midi_byte_stream_assembler_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for the midi byte stream assembler with a running-status predictor
module tb_midi_byte_stream_assembler_top;
    import mbsa_pkg::*;

    localparam int BUF_BYTES = BUFFER_BYTES_DEF;
    localparam int RANDOM_ITEMS = 170;

    typedef enum logic [2:0] {
        PS_READY    = 3'd0,
        PS_TWO      = 3'd1,
        PS_THREE    = 3'd2,
        PS_EXCL     = 3'd3,
        PS_TIMECODE = 3'd4,
        PS_SYSTEM   = 3'd5
    } parse_t;

    class midi_parse_checker;
        result_t     forwarded_q[$];
        parse_t      state;
        logic [1:0]  sys_len;
        int unsigned fill;
        logic [7:0]  status_memo;
        logic [7:0]  store [BUF_BYTES];
        int          errors;

        function new();
            state = PS_READY;
            sys_len = 2'd0;
            fill = 0;
            status_memo = LAST_STATUS_RST;
            errors = 0;
            foreach (store[i]) store[i] = 8'h00;
        endfunction

        function int pending();
            return forwarded_q.size();
        endfunction

        function void push_result(input logic [10:0] done, input logic [1:0] kind,
                                  input logic [127:0] pay, input int unsigned len,
                                  input bit fin);
            result_t r;
            r.done_count = done;
            r.send_kind  = kind;
            r.chunk_low  = pay[63:0];
            r.chunk_high = pay[127:64];
            r.chunk_len  = len[LEN_W-1:0];
            r.last       = fin;
            forwarded_q.push_back(r);
        endfunction

        function void push_count(input logic [10:0] done);
            push_result(done, KIND_NONE, '0, 0, 1'b1);
        endfunction

        // works out every result that one accepted transaction causes
        function void note_item(input item_t it);
            logic [7:0]   b;
            logic [127:0] pay;
            int unsigned  n;
            int unsigned  chunks;
            int unsigned  len;
            b = it.in_byte;
            if (it.mode)
            begin
                push_result(11'd1, KIND_CHUNK, {64'h0, GM_RESET_LOW}, GM_RESET_LEN, 1'b0);
                for (int ch = 0; ch < 16; ch++)
                begin
                    pay = {104'h0, 8'h00, CC_NOTES_OFF, NIBBLE_CC, ch[3:0]};
                    push_result(11'd1, KIND_SHORT, pay, 3, ch == 15);
                end
                return;
            end
            if (b == BYTE_CLOCK || b == BYTE_START || b == BYTE_CONTINUE ||
                b == BYTE_STOP || b == BYTE_SENSING || b == BYTE_SYS_RESET)
            begin
                push_count(11'd1);
                return;
            end
            if (state == PS_READY)
            begin
                if (b[7])
                begin
                    fill = 0;
                    case (b[7:4])
                        // program change and channel pressure
                        4'hc, 4'hd: state = PS_TWO;
                        4'h8, 4'h9, 4'ha, 4'hb, 4'he:
                        begin
                            state = PS_THREE;
                            status_memo = b;
                        end
                        default:
                        begin
                            if (b == BYTE_SOX)
                                state = PS_EXCL;
                            else if (b == BYTE_TIMECODE)
                                state = PS_TIMECODE;
                            else if (b == BYTE_SONG_POS)
                            begin
                                state = PS_SYSTEM;
                                sys_len = 2'd3;
                            end
                            else if (b == BYTE_SONG_SEL)
                            begin
                                state = PS_SYSTEM;
                                sys_len = 2'd2;
                            end
                            else if (b == BYTE_TUNE_REQ)
                            begin
                                state = PS_SYSTEM;
                                sys_len = 2'd1;
                            end
                            else
                            begin
                                push_count(11'd1);
                                return;
                            end
                        end
                    endcase
                end
                else
                begin
                    // running status
                    store[0] = status_memo;
                    fill = 1;
                    state = PS_THREE;
                end
            end
            if (fill < BUF_BYTES)
                store[fill] = b;
            fill = (fill + 1) & 11'h7ff;

            case (state)
                PS_TWO:
                    if (fill >= 2)
                    begin
                        pay = {112'h0, store[1] & DATA_MASK, store[0]};
                        state = PS_READY;
                        push_result(11'd2, KIND_SHORT, pay, 2, 1'b1);
                        return;
                    end
                PS_THREE:
                    if (fill >= 3)
                    begin
                        pay = {104'h0, store[2] & DATA_MASK, store[1] & DATA_MASK, store[0]};
                        state = PS_READY;
                        push_result(11'd3, KIND_SHORT, pay, 3, 1'b1);
                        return;
                    end
                PS_EXCL:
                begin
                    if (b == BYTE_EOX)
                    begin
                        n = (fill > BUF_BYTES) ? BUF_BYTES : fill;
                        chunks = (n + 15) / 16;
                        for (int c = 0; c < chunks; c++)
                        begin
                            len = n - c * 16;
                            if (len > 16)
                                len = 16;
                            pay = '0;
                            for (int i = 0; i < len; i++)
                                pay[8*i +: 8] = store[c * 16 + i];
                            push_result(n[10:0], KIND_CHUNK, pay, len, c + 1 == chunks);
                        end
                        state = PS_READY;
                        return;
                    end
                    // store full without eox: message dropped
                    if (fill >= BUF_BYTES)
                        state = PS_READY;
                end
                PS_TIMECODE:
                    if (fill >= 2)
                    begin
                        if (b == BYTE_NON_RT || b == BYTE_RT)
                            state = PS_EXCL;
                        else
                        begin
                            state = PS_READY;
                            push_count(11'd2);
                            return;
                        end
                    end
                PS_SYSTEM:
                    if (fill >= sys_len)
                    begin
                        state = PS_READY;
                        push_count({9'd0, sys_len});
                        return;
                    end
                default: ;
            endcase
            push_count(11'd0);
        endfunction

        task flag_mismatch(input string what);
            errors++;
            if (errors <= 60)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task compare_lane(input string name, input logic [63:0] got, input logic [63:0] want);
            if (got !== want)
                flag_mismatch($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_result(input result_t got);
            result_t want;
            if (forwarded_q.size() == 0)
            begin
                flag_mismatch($sformatf("result %h with nothing pending", got));
                return;
            end
            want = forwarded_q.pop_front();
            compare_lane("done_count", 64'(got.done_count), 64'(want.done_count));
            compare_lane("send_kind", 64'(got.send_kind), 64'(want.send_kind));
            compare_lane("chunk_low", got.chunk_low, want.chunk_low);
            compare_lane("chunk_high", got.chunk_high, want.chunk_high);
            compare_lane("chunk_len", 64'(got.chunk_len), 64'(want.chunk_len));
            compare_lane("last", 64'(got.last), 64'(want.last));
        endtask
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    midi_parse_checker tracker;
    bit                calm = 1'b0;
    int unsigned       fed = 0;

    midi_byte_stream_assembler_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        result_ready <= rst_n && (calm || $urandom_range(0, 99) >= 38);

    // both handshakes are stable between edges, so sample them at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                tracker.note_item(item);
            if (result_valid && result_ready)
                tracker.check_result(result);
        end
    end

    initial
    begin
        #2_000_000;
        $display("midi_byte_stream_assembler_top verification failed");
        $finish;
    end

    // called at a rising edge, returns at the edge that completes the transaction
    task automatic send(input logic m, input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 38)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= {m, b};
        @(negedge clk);
        while (!item_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_realtime();
        case ($urandom_range(0, 5))
            0: return BYTE_CLOCK;
            1: return BYTE_START;
            2: return BYTE_CONTINUE;
            3: return BYTE_STOP;
            4: return BYTE_SENSING;
            default: return BYTE_SYS_RESET;
        endcase
    endfunction

    function automatic logic [7:0] channel_data();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] sysex_data();
        logic [7:0] r;
        r = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
                                          8'($urandom_range(0, 127));
        return (r == BYTE_EOX) ? 8'h00 : r;
    endfunction

    // real-time bytes are sprinkled in but not counted
    task automatic send_counted(input logic m, input logic [7:0] b);
        if ($urandom_range(0, 9) == 0)
            send(1'b0, pick_realtime());
        send(m, b);
        fed++;
    endtask

    task automatic sysex_tail();
        int unsigned n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(37, 300) : $urandom_range(0, 36);
        for (int i = 0; i < n; i++)
            send_counted(1'b0, sysex_data());
        send_counted(1'b0, BYTE_EOX);
    endtask

    task automatic random_message();
        int unsigned pick;
        logic [3:0]  hi;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 22)
        begin
            hi = 4'($urandom_range(8, 12));
            if (hi == 4'hc)
                hi = 4'he;
            send_counted(1'b0, {hi, 4'($urandom_range(0, 15))});
            send_counted(1'b0, channel_data());
            send_counted(1'b0, channel_data());
        end
        else if (pick < 32)
        begin
            send_counted(1'b0, 8'($urandom_range(0, 127)));
            send_counted(1'b0, channel_data());
        end
        else if (pick < 47)
        begin
            hi = 4'($urandom_range(12, 13));
            send_counted(1'b0, {hi, 4'($urandom_range(0, 15))});
            send_counted(1'b0, channel_data());
        end
        else if (pick < 62)
        begin
            send_counted(1'b0, BYTE_SOX);
            sysex_tail();
        end
        else if (pick < 67)
        begin
            send_counted(1'b0, BYTE_TIMECODE);
            if ($urandom_range(0, 1))
            begin
                send_counted(1'b0, $urandom_range(0, 1) ? BYTE_NON_RT : BYTE_RT);
                sysex_tail();
            end
            else
            begin
                b = 8'($urandom_range(0, 125));
                send_counted(1'b0, b);
            end
        end
        else if (pick < 75)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    send_counted(1'b0, BYTE_SONG_POS);
                    send_counted(1'b0, channel_data());
                    send_counted(1'b0, channel_data());
                end
                1:
                begin
                    send_counted(1'b0, BYTE_SONG_SEL);
                    send_counted(1'b0, channel_data());
                end
                default: send_counted(1'b0, BYTE_TUNE_REQ);
            endcase
        end
        else if (pick < 80)
            send_counted(1'b1, 8'($urandom_range(0, 255)));
        else if (pick < 85)
        begin
            case ($urandom_range(0, 4))
                0: b = 8'hf4;
                1: b = 8'hf5;
                2: b = 8'hf9;
                3: b = 8'hfd;
                default: b = BYTE_EOX;
            endcase
            send_counted(1'b0, b);
        end
        else
        begin
            // noise, may break or open a message
            repeat ($urandom_range(1, 3))
                send_counted(1'b0, 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset command, note off with extreme values, running status
        send(1'b1, 8'hff);
        send(1'b0, 8'h80);
        send(1'b0, 8'h00);
        send(1'b0, 8'h7f);
        send(1'b0, 8'h45);
        send(1'b0, BYTE_CLOCK);
        send(1'b0, 8'h12);
        // status bytes inside channel messages are masked
        send(1'b0, 8'hc5);
        send(1'b0, 8'h95);
        send(1'b0, 8'hef);
        send(1'b0, 8'h7f);
        send(1'b0, 8'h80);
        send(1'b0, 8'hdf);
        send(1'b0, BYTE_START);
        send(1'b0, 8'h00);
        // system common absorbed
        send(1'b0, BYTE_SONG_POS);
        send(1'b0, BYTE_CONTINUE);
        send(1'b0, 8'h01);
        send(1'b0, 8'h02);
        send(1'b0, BYTE_SONG_SEL);
        send(1'b0, 8'h05);
        send(1'b0, BYTE_TUNE_REQ);
        // stray status while idle
        send(1'b0, 8'hf4);
        send(1'b0, 8'hf5);
        send(1'b0, 8'hf9);
        send(1'b0, 8'hfd);
        send(1'b0, BYTE_EOX);
        send(1'b0, BYTE_STOP);
        // time code, plain and turned into an exclusive
        send(1'b0, BYTE_TIMECODE);
        send(1'b0, 8'h20);
        send(1'b0, BYTE_TIMECODE);
        send(1'b0, BYTE_RT);
        send(1'b0, BYTE_SENSING);
        send(1'b0, 8'h90);
        send(1'b0, BYTE_EOX);
        // reset command in the middle of a note
        send(1'b0, 8'h9a);
        send(1'b0, 8'h40);
        send(1'b1, 8'h00);
        send(1'b0, BYTE_SYS_RESET);
        send(1'b0, 8'h7f);

        while (fed < RANDOM_ITEMS)
        begin
            calm = (fed >= 90 && fed < 150);
            random_message();
        end
        calm = 1'b0;
        item_valid <= 1'b0;

        for (int k = 0; k < 100000 && tracker.pending() != 0; k++)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.flag_mismatch($sformatf("%0d results never arrived", tracker.pending()));
        if (tracker.errors == 0)
            $display("midi_byte_stream_assembler_top verification clean");
        else
            $display("midi_byte_stream_assembler_top verification failed");
        $finish;
    end
endmodule

[midi_byte_stream_assembler_top.f]
src/mbsa_pkg.sv
src/mbsa_ctrl.sv
src/mbsa_datapath.sv
src/midi_byte_stream_assembler_top.sv
tb/tb_midi_byte_stream_assembler_top.sv
